>>> rtl/core/tsts_pkg.sv
// tsts_pkg: shared types and constants for the task slot tick scheduler
package tsts_pkg;

  // default configuration
  localparam int DEF_SLOTS      = 8;
  localparam int DEF_TICK_WIDTH = 16;

  // action codes
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_CLEAR = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_TAKE  = 3'd4;

  // saturation limit of the pending run count
  localparam logic [7:0] RUN_MAX = 8'hFF;

  // request payload
  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  slot;
    logic [15:0] delay;
    logic [15:0] period;
  } req_t;

  // result payload
  typedef struct packed {
    logic [7:0]  due_mask;
    logic [7:0]  run_count;
    logic        slot_present;
    logic [15:0] slot_delay;
  } res_t;

  // control handed to the update unit for the slot at the head of the ring
  typedef struct packed {
    logic [2:0] action;
    logic       hit;
  } upd_ctrl_t;

endpackage

>>> rtl/core/tsts_cell.sv
// tsts_cell: one task slot of the ring, passes its contents on every shift
module tsts_cell #(
  parameter int TICK_WIDTH = tsts_pkg::DEF_TICK_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  shift_en,
  input  logic                  present_in,
  input  logic [TICK_WIDTH-1:0] delay_in,
  input  logic [TICK_WIDTH-1:0] period_in,
  input  logic [7:0]            runs_in,
  output logic                  present_out,
  output logic [TICK_WIDTH-1:0] delay_out,
  output logic [TICK_WIDTH-1:0] period_out,
  output logic [7:0]            runs_out
);

  logic                  present_r;
  logic [TICK_WIDTH-1:0] delay_r;
  logic [TICK_WIDTH-1:0] period_r;
  logic [7:0]            runs_r;

  // present flag, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
    end else if (shift_en) begin
      present_r <= present_in;
    end
  end

  // counters and period, meaningful only once written
  always_ff @(posedge clk) begin
    if (shift_en) begin
      delay_r  <= delay_in;
      period_r <= period_in;
      runs_r   <= runs_in;
    end
  end

  assign present_out = present_r;
  assign delay_out   = delay_r;
  assign period_out  = period_r;
  assign runs_out    = runs_r;

endmodule

>>> rtl/core/tsts_upd.sv
// tsts_upd: applies the current request to the slot leaving the head of the ring
module tsts_upd #(
  parameter int TICK_WIDTH = tsts_pkg::DEF_TICK_WIDTH
) (
  input  tsts_pkg::upd_ctrl_t   ctrl,
  input  logic [15:0]           req_delay,
  input  logic [15:0]           req_period,
  input  logic                  present_in,
  input  logic [TICK_WIDTH-1:0] delay_in,
  input  logic [TICK_WIDTH-1:0] period_in,
  input  logic [7:0]            runs_in,
  output logic                  present_out,
  output logic [TICK_WIDTH-1:0] delay_out,
  output logic [TICK_WIDTH-1:0] period_out,
  output logic [7:0]            runs_out,
  output logic                  became_due
);

  logic [31:0] dly_ext;
  logic [31:0] per_ext;

  // request values fitted to the counter width
  assign dly_ext = {16'b0, req_delay};
  assign per_ext = {16'b0, req_period};

  always_comb begin
    present_out = present_in;
    delay_out   = delay_in;
    period_out  = period_in;
    runs_out    = runs_in;
    became_due  = 1'b0;
    case (ctrl.action)
      // tick: present due slots count a run (saturating) and reload if periodic, the rest count down
      tsts_pkg::ACT_TICK: begin
        if (present_in) begin
          if (delay_in == '0) begin
            became_due = 1'b1;
            if (runs_in != tsts_pkg::RUN_MAX) begin
              runs_out = runs_in + 8'd1;
            end
            if (period_in != '0) begin
              delay_out = period_in;
            end
          end else begin
            delay_out = delay_in - TICK_WIDTH'(1);
          end
        end
      end
      // write: load a fresh task
      tsts_pkg::ACT_WRITE: begin
        if (ctrl.hit) begin
          present_out = 1'b1;
          delay_out   = dly_ext[TICK_WIDTH-1:0];
          period_out  = per_ext[TICK_WIDTH-1:0];
          runs_out    = 8'd0;
        end
      end
      // clear: drop the task
      tsts_pkg::ACT_CLEAR: begin
        if (ctrl.hit) begin
          present_out = 1'b0;
          delay_out   = '0;
          period_out  = '0;
          runs_out    = 8'd0;
        end
      end
      // take: one pending run dispatched
      tsts_pkg::ACT_TAKE: begin
        if (ctrl.hit && present_in && (runs_in != 8'd0)) begin
          runs_out = runs_in - 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/task_slot_tick_scheduler_unit.sv
// task_slot_tick_scheduler_unit: top level of the task slot tick scheduler
//
// Request channel: a request (in_req) is taken at a rising edge with start
// high and busy low. Actions are tick, write slot, clear slot, read slot and
// take one pending run.
// Result channel: out_valid is high for exactly one cycle with out_res; the
// receiver cannot stall, so each result must be taken when shown.
// The slots sit in a ring of cells that rotates by one slot per cycle while
// busy is high; the slot leaving the head passes through the update unit and
// re-enters at the tail. Every request walks the whole ring once with busy
// high, and the result strobe rises in the same cycle busy falls. No new
// request is taken until the walk is done, as the single update unit at the
// head of the ring serves one request at a time. A new request
// may be taken in the same cycle the previous result is shown.
// Reset clears all present flags and the control state; delay, period and
// run count of a slot hold nothing useful until that slot is written.
module task_slot_tick_scheduler_unit #(
  parameter int SLOTS      = tsts_pkg::DEF_SLOTS,
  parameter int TICK_WIDTH = tsts_pkg::DEF_TICK_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tsts_pkg::req_t in_req,
  output logic           out_valid,
  output tsts_pkg::res_t out_res
);

  localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // ring signals, one entry per cell
  logic                  cell_pres [SLOTS];
  logic [TICK_WIDTH-1:0] cell_dly  [SLOTS];
  logic [TICK_WIDTH-1:0] cell_per  [SLOTS];
  logic [7:0]            cell_runs [SLOTS];
  logic                  nxt_pres  [SLOTS];
  logic [TICK_WIDTH-1:0] nxt_dly   [SLOTS];
  logic [TICK_WIDTH-1:0] nxt_per   [SLOTS];
  logic [7:0]            nxt_runs  [SLOTS];

  logic                  busy_r;
  logic [CW-1:0]         cnt_r;
  tsts_pkg::req_t        req_r;
  logic [7:0]            due_r;
  logic [7:0]            due_nxt;
  logic [7:0]            cap_runs_r;
  logic [7:0]            cap_runs_nxt;
  logic                  cap_pres_r;
  logic                  cap_pres_nxt;
  logic [15:0]           cap_dly_r;
  logic [15:0]           cap_dly_nxt;
  logic                  out_valid_r;
  tsts_pkg::res_t        out_res_r;
  tsts_pkg::res_t        out_res_nxt;

  tsts_pkg::upd_ctrl_t   ctrl;
  logic                  slot_ok;
  logic                  upd_pres;
  logic [TICK_WIDTH-1:0] upd_dly;
  logic [TICK_WIDTH-1:0] upd_per;
  logic [7:0]            upd_runs;
  logic                  upd_due;
  logic [31:0]           upd_dly_ext;
  logic                  last_step;

  // addressed slot within the table, and is it at the head now
  assign slot_ok     = ({29'b0, req_r.slot} < 32'(SLOTS));
  assign ctrl.action = req_r.action;
  assign ctrl.hit    = slot_ok && (32'(cnt_r) == {29'b0, req_r.slot});
  assign last_step   = (cnt_r == CW'(SLOTS - 1));

  // update unit between head and tail of the ring
  tsts_upd #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_upd (
    .ctrl       (ctrl),
    .req_delay  (req_r.delay),
    .req_period (req_r.period),
    .present_in (cell_pres[0]),
    .delay_in   (cell_dly[0]),
    .period_in  (cell_per[0]),
    .runs_in    (cell_runs[0]),
    .present_out(upd_pres),
    .delay_out  (upd_dly),
    .period_out (upd_per),
    .runs_out   (upd_runs),
    .became_due (upd_due)
  );

  // ring of slot cells, each takes its upper neighbour on a shift, the tail takes the update output
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      assign nxt_pres[i] = upd_pres;
      assign nxt_dly[i]  = upd_dly;
      assign nxt_per[i]  = upd_per;
      assign nxt_runs[i] = upd_runs;
    end else begin : g_mid
      assign nxt_pres[i] = cell_pres[i+1];
      assign nxt_dly[i]  = cell_dly[i+1];
      assign nxt_per[i]  = cell_per[i+1];
      assign nxt_runs[i] = cell_runs[i+1];
    end
    tsts_cell #(
      .TICK_WIDTH(TICK_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (busy_r),
      .present_in (nxt_pres[i]),
      .delay_in   (nxt_dly[i]),
      .period_in  (nxt_per[i]),
      .runs_in    (nxt_runs[i]),
      .present_out(cell_pres[i]),
      .delay_out  (cell_dly[i]),
      .period_out (cell_per[i]),
      .runs_out   (cell_runs[i])
    );
  end

  // due mask and addressed slot capture for the current step
  assign upd_dly_ext = 32'(upd_dly);
  always_comb begin
    due_nxt      = due_r;
    cap_runs_nxt = cap_runs_r;
    cap_pres_nxt = cap_pres_r;
    cap_dly_nxt  = cap_dly_r;
    for (int b = 0; b < 8; b++) begin
      if ((32'(cnt_r) == b) && upd_due) begin
        due_nxt[b] = 1'b1;
      end
    end
    if (ctrl.hit) begin
      cap_runs_nxt = upd_runs;
      cap_pres_nxt = upd_pres;
      cap_dly_nxt  = upd_dly_ext[15:0];
    end
  end

  // result assembled at the end of the walk
  always_comb begin
    out_res_nxt.due_mask     = (req_r.action == tsts_pkg::ACT_TICK) ? due_nxt : 8'd0;
    out_res_nxt.run_count    = slot_ok ? cap_runs_nxt : 8'd0;
    out_res_nxt.slot_present = slot_ok ? cap_pres_nxt : 1'b0;
    out_res_nxt.slot_delay   = slot_ok ? cap_dly_nxt : 16'd0;
  end

  // control: request capture, step counter and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        if (last_step) begin
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (start) begin
        req_r      <= in_req;
        due_r      <= 8'd0;
        cap_runs_r <= 8'd0;
        cap_pres_r <= 1'b0;
        cap_dly_r  <= 16'd0;
      end
    end else begin
      due_r      <= due_nxt;
      cap_runs_r <= cap_runs_nxt;
      cap_pres_r <= cap_pres_nxt;
      cap_dly_r  <= cap_dly_nxt;
      if (last_step) begin
        out_res_r <= out_res_nxt;
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
